// ----- design/sbe_pkg.sv -----
package sbe_pkg;

    localparam int DATA_DEPTH_DEF   = 256;
    localparam int RETURN_DEPTH_DEF = 64;
    localparam int CELL_BITS_DEF    = 32;
    localparam int PC_BITS_DEF      = 16;
    localparam int VAR_COUNT_DEF    = 16;

    // Opcodes
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_LIT   = 8'h01;
    localparam logic [7:0] OP_LITB  = 8'h02;
    localparam logic [7:0] OP_PC    = 8'h04;
    localparam logic [7:0] OP_JMP   = 8'h05;
    localparam logic [7:0] OP_JMPL  = 8'h06;
    localparam logic [7:0] OP_JZ    = 8'h07;
    localparam logic [7:0] OP_BYE   = 8'h0f;
    localparam logic [7:0] OP_ADD   = 8'h10;
    localparam logic [7:0] OP_SUB   = 8'h11;
    localparam logic [7:0] OP_MUL   = 8'h12;
    localparam logic [7:0] OP_DIV   = 8'h13;
    localparam logic [7:0] OP_MOD   = 8'h14;
    localparam logic [7:0] OP_AND   = 8'h15;
    localparam logic [7:0] OP_OR    = 8'h16;
    localparam logic [7:0] OP_XOR   = 8'h17;
    localparam logic [7:0] OP_LSH   = 8'h18;
    localparam logic [7:0] OP_RSH   = 8'h19;
    localparam logic [7:0] OP_SLT   = 8'h1a;
    localparam logic [7:0] OP_ULT   = 8'h1b;
    localparam logic [7:0] OP_EQ    = 8'h1c;
    localparam logic [7:0] OP_DUP   = 8'h20;
    localparam logic [7:0] OP_SWAP  = 8'h21;
    localparam logic [7:0] OP_DROP  = 8'h22;
    localparam logic [7:0] OP_TOR   = 8'h23;
    localparam logic [7:0] OP_FROMR = 8'h24;
    localparam logic [7:0] OP_STKCNT = 8'h25;
    localparam logic [7:0] OP_CELL  = 8'h30;
    localparam logic [7:0] OP_CHAR  = 8'h31;
    localparam logic [7:0] OP_VARR  = 8'h38;
    localparam logic [7:0] OP_VARW  = 8'h39;
    localparam logic [7:0] OP_EMIT  = 8'h48;
    // Recognized but not implemented
    localparam logic [7:0] OP_U08   = 8'h08;
    localparam logic [7:0] OP_U09   = 8'h09;
    localparam logic [7:0] OP_U0A   = 8'h0a;
    localparam logic [7:0] OP_U28   = 8'h28;
    localparam logic [7:0] OP_U29   = 8'h29;
    localparam logic [7:0] OP_U2A   = 8'h2a;
    localparam logic [7:0] OP_U2B   = 8'h2b;
    localparam logic [7:0] OP_U2C   = 8'h2c;
    localparam logic [7:0] OP_U3A   = 8'h3a;
    localparam logic [7:0] OP_U40   = 8'h40;
    localparam logic [7:0] OP_U41   = 8'h41;
    localparam logic [7:0] OP_U44   = 8'h44;
    localparam logic [7:0] OP_U45   = 8'h45;
    localparam logic [7:0] OP_U46   = 8'h46;

    // Status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_HALT = 3'd1;
    localparam logic [2:0] ST_UNK  = 3'd2;
    localparam logic [2:0] ST_UNF  = 3'd3;
    localparam logic [2:0] ST_OVF  = 3'd4;
    localparam logic [2:0] ST_RET  = 3'd5;
    localparam logic [2:0] ST_DIVZ = 3'd6;
    localparam logic [2:0] ST_UNS  = 3'd7;

    typedef struct packed {
        logic [7:0] req_type;
        logic [7:0] operand_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic signed [31:0] top_value;
        logic [8:0]         stack_depth;
        logic               emit_valid;
        logic [7:0]         emit_char;
        logic [2:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_DIV,
        MD_MOD
    } t_md_kind;

    typedef struct packed {
        logic     start;
        t_md_kind kind;
    } t_md_ctrl;

endpackage

// ----- design/sbe_ram.sv -----
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sbe_muldiv.sv -----
module sbe_muldiv #(
    parameter int W = sbe_pkg::CELL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbe_pkg::t_md_ctrl i_ctrl,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_c,
    output logic              o_done,
    output logic [W-1:0]      o_result
);

    localparam int CW = $clog2(W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    sbe_pkg::t_md_kind r_kind;
    logic              r_negq;
    logic              r_negr;
    logic [W-1:0]      r_q;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_dsr;
    logic              r_done;
    logic [W-1:0]      r_result;

    logic [W:0]   w_sh;
    logic [W:0]   w_diff;
    logic [W-1:0] w_acc;
    logic [W-1:0] w_abs_a;
    logic [W-1:0] w_abs_c;

    assign w_sh    = {r_rem, r_q[W-1]};
    assign w_diff  = w_sh - {1'b0, r_dsr};
    assign w_acc   = r_rem + (r_q[0] ? r_dsr : '0);
    assign w_abs_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_c = i_c[W-1] ? (~i_c + 1'b1) : i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctrl.start) begin
                        r_kind  <= i_ctrl.kind;
                        r_negq  <= i_a[W-1] ^ i_c[W-1];
                        r_negr  <= i_a[W-1];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        if (i_ctrl.kind == sbe_pkg::MD_MUL) begin
                            r_q   <= i_c;
                            r_dsr <= i_a;
                        end else begin
                            r_q   <= w_abs_a;
                            r_dsr <= w_abs_c;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_kind == sbe_pkg::MD_MUL) begin
                        // shift-add, one multiplier bit per cycle
                        r_rem <= w_acc;
                        r_dsr <= r_dsr << 1;
                        r_q   <= r_q >> 1;
                    end else if (!w_diff[W]) begin
                        r_rem <= w_diff[W-1:0];
                        r_q   <= {r_q[W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_sh[W-1:0];
                        r_q   <= {r_q[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    case (r_kind)
                        sbe_pkg::MD_MUL: r_result <= r_rem;
                        sbe_pkg::MD_DIV: r_result <= r_negq ? (~r_q + 1'b1) : r_q;
                        default:         r_result <= r_negr ? (~r_rem + 1'b1) : r_rem;
                    endcase
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- design/stack_bytecode_executor_top.sv -----
// Byte-coded stack machine: each input transaction carries one opcode and the byte after
// it, and each yields exactly one result transaction with the next pc, new top of stack,
// depth, any emitted character and a status. Items are executed one at a time; a new item
// is taken while the previous result still waits at the output. The sequencer walks the
// single-read-port data stack RAM in order: read top, read second, execute, write back,
// re-read the new top; swap adds a second write-back step. Faults and items after halt
// go from the first read straight to the re-read of the top, divide or modulo by zero
// after both reads. Multiply, divide and modulo wait on the bit-serial shared mul/div
// unit. The input is ready again as soon as the result is registered; while the output
// register holds an unaccepted result, the finished result waits to be registered.
// No clearing pass is needed after reset; variable cells read as zero until written.
module stack_bytecode_executor_top #(
    parameter int DATA_DEPTH   = sbe_pkg::DATA_DEPTH_DEF,
    parameter int RETURN_DEPTH = sbe_pkg::RETURN_DEPTH_DEF,
    parameter int CELL_BITS    = sbe_pkg::CELL_BITS_DEF,
    parameter int PC_BITS      = sbe_pkg::PC_BITS_DEF,
    parameter int VAR_COUNT    = sbe_pkg::VAR_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sbe_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sbe_pkg::t_out_item o_out
);

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int SHW = $clog2(CELL_BITS);
    localparam int EXW = (CELL_BITS > 32) ? CELL_BITS : 32;
    localparam logic [CELL_BITS-1:0] CELL_BYTES = CELL_BITS'(CELL_BITS / 8);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_EXEC,
        S_WAIT,
        S_APPLY,
        S_SWAP2,
        S_FINRD,
        S_FIN
    } t_state;

    t_state               r_state;
    logic [PC_BITS-1:0]   r_pc;
    logic [PC_BITS-1:0]   r_npc;
    logic [DCW-1:0]       r_dcnt;
    logic [RCW-1:0]       r_rcnt;
    logic                 r_halted;
    logic [VAR_COUNT-1:0] r_vvalid;
    logic [7:0]           r_op;
    logic [7:0]           r_b;
    logic [CELL_BITS-1:0] r_top;
    logic [CELL_BITS-1:0] r_sec;
    logic [CELL_BITS-1:0] r_res;
    logic [2:0]           r_st;
    logic                 r_ev;
    logic [7:0]           r_ec;
    logic                 r_out_valid;
    sbe_pkg::t_out_item   r_out;

    logic [PC_BITS-1:0]   w_pc1;
    logic [PC_BITS-1:0]   w_pc2;
    logic [PC_BITS-1:0]   w_apc;
    logic [DCW-1:0]       w_cm1;
    logic [DCW-1:0]       w_cm2;
    logic [RCW-1:0]       w_rcm1;
    logic                 w_full;
    logic [2:0]           w_fault;
    logic [16:0]          w_vrem;
    logic [VAW-1:0]       w_vi;
    logic [CELL_BITS-1:0] w_vval;
    logic [CELL_BITS-1:0] w_alu;
    logic                 w_is_md;
    logic                 w_is_dm;
    logic signed [EXW-1:0] w_topext;

    logic                 d_we;
    logic [DAW-1:0]       d_waddr;
    logic [CELL_BITS-1:0] d_wdata;
    logic                 d_re;
    logic [DAW-1:0]       d_raddr;
    logic [CELL_BITS-1:0] d_rdata;
    logic                 rs_we;
    logic                 rs_re;
    logic [CELL_BITS-1:0] rs_rdata;
    logic                 v_we;
    logic                 v_re;
    logic [CELL_BITS-1:0] v_rdata;

    sbe_pkg::t_md_ctrl    md_ctrl;
    logic                 md_done;
    logic [CELL_BITS-1:0] md_result;

    assign w_pc1  = r_pc + PC_BITS'(1);
    assign w_pc2  = r_pc + PC_BITS'(2);
    assign w_cm1  = r_dcnt - DCW'(1);
    assign w_cm2  = r_dcnt - DCW'(2);
    assign w_rcm1 = r_rcnt - RCW'(1);
    assign w_full = r_dcnt >= DCW'(DATA_DEPTH);
    assign w_is_dm = (r_op == sbe_pkg::OP_DIV) || (r_op == sbe_pkg::OP_MOD);
    assign w_is_md = w_is_dm || (r_op == sbe_pkg::OP_MUL);
    assign w_vval  = r_vvalid[w_vi] ? v_rdata : '0;
    assign w_topext = EXW'($signed(d_rdata));

    // operand byte modulo VAR_COUNT, restoring compare-subtract over the byte's 8 bits
    always_comb begin
        w_vrem = {9'd0, r_b};
        for (int i = 7; i >= 0; i--) begin
            if (w_vrem >= (17'(VAR_COUNT) << i)) begin
                w_vrem = w_vrem - (17'(VAR_COUNT) << i);
            end
        end
        w_vi = VAW'(w_vrem);
    end

    always_comb begin
        w_fault = sbe_pkg::ST_OK;
        case (r_op)
            sbe_pkg::OP_NOP, sbe_pkg::OP_BYE: w_fault = sbe_pkg::ST_OK;
            sbe_pkg::OP_LIT, sbe_pkg::OP_PC, sbe_pkg::OP_STKCNT, sbe_pkg::OP_CELL,
            sbe_pkg::OP_CHAR, sbe_pkg::OP_VARR: begin
                if (w_full) w_fault = sbe_pkg::ST_OVF;
            end
            sbe_pkg::OP_LITB, sbe_pkg::OP_JMP, sbe_pkg::OP_JMPL, sbe_pkg::OP_DROP,
            sbe_pkg::OP_VARW, sbe_pkg::OP_EMIT: begin
                if (r_dcnt == '0) w_fault = sbe_pkg::ST_UNF;
            end
            sbe_pkg::OP_DUP: begin
                if (r_dcnt == '0) w_fault = sbe_pkg::ST_UNF;
                else if (w_full) w_fault = sbe_pkg::ST_OVF;
            end
            sbe_pkg::OP_JZ, sbe_pkg::OP_SWAP, sbe_pkg::OP_ADD, sbe_pkg::OP_SUB,
            sbe_pkg::OP_MUL, sbe_pkg::OP_DIV, sbe_pkg::OP_MOD, sbe_pkg::OP_AND,
            sbe_pkg::OP_OR, sbe_pkg::OP_XOR, sbe_pkg::OP_LSH, sbe_pkg::OP_RSH,
            sbe_pkg::OP_SLT, sbe_pkg::OP_ULT, sbe_pkg::OP_EQ: begin
                if (r_dcnt < DCW'(2)) w_fault = sbe_pkg::ST_UNF;
            end
            sbe_pkg::OP_TOR: begin
                if (r_dcnt == '0) w_fault = sbe_pkg::ST_UNF;
                else if (r_rcnt >= RCW'(RETURN_DEPTH)) w_fault = sbe_pkg::ST_RET;
            end
            sbe_pkg::OP_FROMR: begin
                if (r_rcnt == '0) w_fault = sbe_pkg::ST_RET;
                else if (w_full) w_fault = sbe_pkg::ST_OVF;
            end
            sbe_pkg::OP_U08, sbe_pkg::OP_U09, sbe_pkg::OP_U0A, sbe_pkg::OP_U28,
            sbe_pkg::OP_U29, sbe_pkg::OP_U2A, sbe_pkg::OP_U2B, sbe_pkg::OP_U2C,
            sbe_pkg::OP_U3A, sbe_pkg::OP_U40, sbe_pkg::OP_U41, sbe_pkg::OP_U44,
            sbe_pkg::OP_U45, sbe_pkg::OP_U46: w_fault = sbe_pkg::ST_UNS;
            default: w_fault = sbe_pkg::ST_UNK;
        endcase
    end

    // combinational ALU: second (a) against top (c)
    always_comb begin
        case (r_op)
            sbe_pkg::OP_ADD: w_alu = r_sec + r_top;
            sbe_pkg::OP_SUB: w_alu = r_sec - r_top;
            sbe_pkg::OP_AND: w_alu = r_sec & r_top;
            sbe_pkg::OP_OR:  w_alu = r_sec | r_top;
            sbe_pkg::OP_XOR: w_alu = r_sec ^ r_top;
            sbe_pkg::OP_LSH: w_alu = (r_top >= CELL_BITS'(CELL_BITS)) ? '0
                                     : (r_sec << r_top[SHW-1:0]);
            sbe_pkg::OP_RSH: w_alu = (r_top >= CELL_BITS'(CELL_BITS)) ? '0
                                     : (r_sec >> r_top[SHW-1:0]);
            sbe_pkg::OP_SLT: w_alu = ($signed(r_sec) < $signed(r_top)) ? '1 : '0;
            sbe_pkg::OP_ULT: w_alu = (r_sec < r_top) ? '1 : '0;
            default:         w_alu = (r_sec == r_top) ? '1 : '0;
        endcase
    end

    always_comb begin
        case (r_op)
            sbe_pkg::OP_LIT, sbe_pkg::OP_LITB, sbe_pkg::OP_VARR,
            sbe_pkg::OP_VARW: w_apc = w_pc2;
            sbe_pkg::OP_JMP, sbe_pkg::OP_JMPL: w_apc = PC_BITS'(r_top);
            sbe_pkg::OP_JZ: w_apc = (r_sec == '0) ? PC_BITS'(r_top) : w_pc1;
            default: w_apc = w_pc1;
        endcase
    end

    // stack RAM port control
    always_comb begin
        d_re    = (r_state == S_RD1) || (r_state == S_RD2) || (r_state == S_FINRD);
        d_raddr = (r_state == S_RD2) ? w_cm2[DAW-1:0] : w_cm1[DAW-1:0];
        d_we    = 1'b0;
        d_waddr = r_dcnt[DAW-1:0];
        d_wdata = r_top;
        if (r_state == S_SWAP2) begin
            d_we    = 1'b1;
            d_waddr = w_cm2[DAW-1:0];
            d_wdata = r_top;
        end else if (r_state == S_APPLY) begin
            case (r_op)
                sbe_pkg::OP_LIT: begin
                    d_we = 1'b1; d_wdata = CELL_BITS'($signed(r_b));
                end
                sbe_pkg::OP_LITB: begin
                    d_we = 1'b1; d_waddr = w_cm1[DAW-1:0];
                    d_wdata = (r_top << 8) | CELL_BITS'(r_b);
                end
                sbe_pkg::OP_PC: begin
                    d_we = 1'b1; d_wdata = CELL_BITS'(w_pc1);
                end
                sbe_pkg::OP_JMPL: begin
                    d_we = 1'b1; d_waddr = w_cm1[DAW-1:0]; d_wdata = CELL_BITS'(w_pc1);
                end
                sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
                sbe_pkg::OP_MOD, sbe_pkg::OP_AND, sbe_pkg::OP_OR, sbe_pkg::OP_XOR,
                sbe_pkg::OP_LSH, sbe_pkg::OP_RSH, sbe_pkg::OP_SLT, sbe_pkg::OP_ULT,
                sbe_pkg::OP_EQ: begin
                    d_we = 1'b1; d_waddr = w_cm2[DAW-1:0]; d_wdata = r_res;
                end
                sbe_pkg::OP_DUP: begin
                    d_we = 1'b1; d_wdata = r_top;
                end
                sbe_pkg::OP_SWAP: begin
                    d_we = 1'b1; d_waddr = w_cm1[DAW-1:0]; d_wdata = r_sec;
                end
                sbe_pkg::OP_FROMR: begin
                    d_we = 1'b1; d_wdata = rs_rdata;
                end
                sbe_pkg::OP_STKCNT: begin
                    d_we = 1'b1; d_wdata = CELL_BITS'(r_dcnt);
                end
                sbe_pkg::OP_CELL: begin
                    d_we = 1'b1; d_wdata = CELL_BYTES;
                end
                sbe_pkg::OP_CHAR: begin
                    d_we = 1'b1; d_wdata = CELL_BITS'(1);
                end
                sbe_pkg::OP_VARR: begin
                    d_we = 1'b1; d_wdata = w_vval;
                end
                default: d_we = 1'b0;
            endcase
        end
    end

    assign rs_re = (r_state == S_RD1);
    assign rs_we = (r_state == S_APPLY) && (r_op == sbe_pkg::OP_TOR);
    assign v_re  = (r_state == S_RD1);
    assign v_we  = (r_state == S_APPLY) && (r_op == sbe_pkg::OP_VARW);

    always_comb begin
        md_ctrl.start = (r_state == S_EXEC) && w_is_md && !(w_is_dm && (r_top == '0));
        case (r_op)
            sbe_pkg::OP_MUL: md_ctrl.kind = sbe_pkg::MD_MUL;
            sbe_pkg::OP_DIV: md_ctrl.kind = sbe_pkg::MD_DIV;
            default:         md_ctrl.kind = sbe_pkg::MD_MOD;
        endcase
    end

    sbe_ram #(.WIDTH(CELL_BITS), .DEPTH(DATA_DEPTH)) u_dstack (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    sbe_ram #(.WIDTH(CELL_BITS), .DEPTH(RETURN_DEPTH)) u_rstack (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (r_rcnt[RAW-1:0]),
        .i_wdata (r_top),
        .i_re    (rs_re),
        .i_raddr (w_rcm1[RAW-1:0]),
        .o_rdata (rs_rdata)
    );

    sbe_ram #(.WIDTH(CELL_BITS), .DEPTH(VAR_COUNT)) u_vars (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (w_vi),
        .i_wdata (r_top),
        .i_re    (v_re),
        .i_raddr (w_vi),
        .o_rdata (v_rdata)
    );

    sbe_muldiv #(.W(CELL_BITS)) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (md_ctrl),
        .i_a      (r_sec),
        .i_c      (r_top),
        .o_done   (md_done),
        .o_result (md_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_dcnt      <= '0;
            r_rcnt      <= '0;
            r_halted    <= 1'b0;
            r_vvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result in S_FIN refills the slot in the same cycle
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in.req_type;
                        r_b     <= i_in.operand_byte;
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_ev  <= 1'b0;
                    r_ec  <= '0;
                    if (r_halted) begin
                        r_st    <= sbe_pkg::ST_HALT;
                        r_npc   <= r_pc;
                        r_state <= S_FINRD;
                    end else if (r_op == sbe_pkg::OP_BYE) begin
                        r_halted <= 1'b1;
                        r_st     <= sbe_pkg::ST_HALT;
                        r_pc     <= w_pc1;
                        r_npc    <= w_pc1;
                        r_state  <= S_FINRD;
                    end else if (w_fault != sbe_pkg::ST_OK) begin
                        r_st    <= w_fault;
                        r_npc   <= r_pc;
                        r_state <= S_FINRD;
                    end else begin
                        r_st    <= sbe_pkg::ST_OK;
                        r_npc   <= w_pc1;
                        r_state <= S_RD2;
                    end
                end
                S_RD2: begin
                    r_top   <= d_rdata;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_sec   <= d_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_is_dm && (r_top == '0)) begin
                        r_st    <= sbe_pkg::ST_DIVZ;
                        r_npc   <= r_pc;
                        r_state <= S_FINRD;
                    end else if (w_is_md) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_res   <= w_alu;
                        r_state <= S_APPLY;
                    end
                end
                S_WAIT: begin
                    if (md_done) begin
                        r_res   <= md_result;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_pc    <= w_apc;
                    r_npc   <= w_apc;
                    r_state <= (r_op == sbe_pkg::OP_SWAP) ? S_SWAP2 : S_FINRD;
                    case (r_op)
                        sbe_pkg::OP_LIT, sbe_pkg::OP_PC, sbe_pkg::OP_DUP,
                        sbe_pkg::OP_STKCNT, sbe_pkg::OP_CELL, sbe_pkg::OP_CHAR,
                        sbe_pkg::OP_VARR: r_dcnt <= r_dcnt + DCW'(1);
                        sbe_pkg::OP_JMP, sbe_pkg::OP_DROP, sbe_pkg::OP_ADD,
                        sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
                        sbe_pkg::OP_MOD, sbe_pkg::OP_AND, sbe_pkg::OP_OR,
                        sbe_pkg::OP_XOR, sbe_pkg::OP_LSH, sbe_pkg::OP_RSH,
                        sbe_pkg::OP_SLT, sbe_pkg::OP_ULT, sbe_pkg::OP_EQ:
                            r_dcnt <= w_cm1;
                        sbe_pkg::OP_JZ: r_dcnt <= w_cm2;
                        sbe_pkg::OP_TOR: begin
                            r_dcnt <= w_cm1;
                            r_rcnt <= r_rcnt + RCW'(1);
                        end
                        sbe_pkg::OP_FROMR: begin
                            r_dcnt <= r_dcnt + DCW'(1);
                            r_rcnt <= w_rcm1;
                        end
                        sbe_pkg::OP_VARW: begin
                            r_dcnt           <= w_cm1;
                            r_vvalid[w_vi]   <= 1'b1;
                        end
                        sbe_pkg::OP_EMIT: begin
                            r_dcnt <= w_cm1;
                            r_ev   <= 1'b1;
                            r_ec   <= r_top[7:0];
                        end
                        default: r_dcnt <= r_dcnt;
                    endcase
                end
                S_SWAP2: r_state <= S_FINRD;
                S_FINRD: r_state <= S_FIN;
                S_FIN: begin
                    // hold until the output slot is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out.next_pc     <= 16'(r_npc);
                        r_out.top_value   <= (r_dcnt == '0) ? '0 : w_topext[31:0];
                        r_out.stack_depth <= 9'(r_dcnt);
                        r_out.emit_valid  <= r_ev;
                        r_out.emit_char   <= r_ec;
                        r_out.status      <= r_st;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_dcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DCW'(DATA_DEPTH))
        else $error("data stack count beyond depth");

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RCW'(RETURN_DEPTH))
        else $error("return stack count beyond depth");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted && $stable(r_pc))
        else $error("halted machine changed state");

    a_md_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> r_state == S_WAIT)
        else $error("mul/div result arrived outside wait");

    a_fault_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && (r_st != sbe_pkg::ST_OK) && (r_st != sbe_pkg::ST_HALT)
        |-> r_npc == r_pc)
        else $error("faulting instruction moved the pc");

endmodule
